// ===== rtl/bafs_pkg.sv =====
// Package for the bit addressable flag store: beat types, operation codes, sizes.
package bafs_pkg;

	localparam int FLAG_BYTES_DEF = 32;

	localparam logic [3:0] OP_SET_BIT   = 4'd0;
	localparam logic [3:0] OP_CLR_BIT   = 4'd1;
	localparam logic [3:0] OP_TGL_BIT   = 4'd2;
	localparam logic [3:0] OP_TST_BIT   = 4'd3;
	localparam logic [3:0] OP_TCLR_BIT  = 4'd4;
	localparam logic [3:0] OP_WR_BYTE   = 4'd5;
	localparam logic [3:0] OP_RD_BYTE   = 4'd6;
	localparam logic [3:0] OP_WR_WORD   = 4'd7;
	localparam logic [3:0] OP_RD_WORD   = 4'd8;
	localparam logic [3:0] OP_WR_DWORD  = 4'd9;
	localparam logic [3:0] OP_RD_DWORD  = 4'd10;

	typedef struct packed {
		logic [3:0]  operation;
		logic [7:0]  index;
		logic [31:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        out_of_range;
	} rsp_t;

endpackage

// ===== rtl/bafs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module bafs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bit_addressable_flag_store_unit.sv =====
// Top level of the bit addressable flag store: bit, byte, word and dword access unit.
//
//  port group        dir  role
//  start/busy/cmd    in (busy out)  command beat: taken when start is high and busy is low
//  done/rsp          out  result beat: valid for the single cycle done is high
//
// One command per cycle; busy is always low. The RAM read happens on the edge
// that takes the command, which also loads valid_s1 and the command registers;
// the modify is combinational from those, and done and rsp are registered from them.
// Storage is a RAM of 32-bit rows; a write is forwarded to a following
// command on the same row. Per-row valid bits make the store read zero
// after reset, so no clearing pass is needed.
// The receiver cannot stall; every result beat is taken.
module bit_addressable_flag_store_unit
	import bafs_pkg::*;
#(
	parameter int FLAG_BYTES = FLAG_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	localparam int ROWS = (FLAG_BYTES + 3) / 4;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [8:0] LIM_BYTES = 9'(FLAG_BYTES);
	localparam logic [8:0] LIM_WORDS = 9'(FLAG_BYTES / 2);
	localparam logic [8:0] LIM_DWORDS = 9'(FLAG_BYTES / 4);

	logic             accept;
	logic             oor_in;
	logic [7:0]       row_in;

	logic             valid_s1;
	logic [3:0]       op_s1;
	logic [7:0]       idx_s1;
	logic [31:0]      wdata_s1;
	logic             oor_s1;
	logic [ROW_W-1:0] row_s1;

	logic [ROWS-1:0]  row_vld_q;
	logic             wb_vld_q;
	logic [ROW_W-1:0] wb_row_q;
	logic [31:0]      wb_data_q;

	logic [31:0]      ram_rd;
	logic [31:0]      row_data;
	logic [31:0]      new_row;
	logic             we;
	logic [31:0]      rdata;
	logic [1:0]       lane;
	logic [7:0]       cur_byte;
	logic [7:0]       new_byte;
	logic [7:0]       mask;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		oor_in = 1'b0;
		row_in = 8'd0;
		case (cmd.operation)
			OP_SET_BIT, OP_CLR_BIT, OP_TGL_BIT, OP_TST_BIT, OP_TCLR_BIT: begin
				oor_in = {4'd0, cmd.index[7:3]} >= LIM_BYTES;
				row_in = {5'd0, cmd.index[7:5]};
			end
			OP_WR_BYTE, OP_RD_BYTE: begin
				oor_in = {1'b0, cmd.index} >= LIM_BYTES;
				row_in = {2'd0, cmd.index[7:2]};
			end
			OP_WR_WORD, OP_RD_WORD: begin
				oor_in = {1'b0, cmd.index} >= LIM_WORDS;
				row_in = {1'd0, cmd.index[7:1]};
			end
			OP_WR_DWORD, OP_RD_DWORD: begin
				oor_in = {1'b0, cmd.index} >= LIM_DWORDS;
				row_in = cmd.index;
			end
			default: begin
				oor_in = 1'b0;
				row_in = 8'd0;
			end
		endcase
	end

	bafs_ram #(
		.WIDTH(32),
		.DEPTH(ROWS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(row_s1),
		.wdata(new_row),
		.raddr(row_in[ROW_W-1:0]),
		.rdata(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= cmd.operation;
			idx_s1 <= cmd.index;
			wdata_s1 <= cmd.write_data;
			oor_s1 <= oor_in;
			row_s1 <= row_in[ROW_W-1:0];
		end
	end

	always_comb begin
		if (wb_vld_q && wb_row_q == row_s1) begin
			row_data = wb_data_q;
		end else if (row_vld_q[row_s1]) begin
			row_data = ram_rd;
		end else begin
			row_data = 32'd0;
		end
	end

	always_comb begin
		case (op_s1)
			OP_WR_BYTE, OP_RD_BYTE: lane = idx_s1[1:0];
			default:                lane = idx_s1[4:3];
		endcase
		case (lane)
			2'd0:    cur_byte = row_data[31:24];
			2'd1:    cur_byte = row_data[23:16];
			2'd2:    cur_byte = row_data[15:8];
			default: cur_byte = row_data[7:0];
		endcase
		mask = 8'h80 >> idx_s1[2:0];
	end

	always_comb begin
		new_byte = cur_byte;
		new_row = row_data;
		we = 1'b0;
		rdata = 32'd0;
		case (op_s1)
			OP_SET_BIT: begin
				new_byte = cur_byte | mask;
				we = 1'b1;
			end
			OP_CLR_BIT: begin
				new_byte = cur_byte & ~mask;
				we = 1'b1;
			end
			OP_TGL_BIT: begin
				new_byte = cur_byte ^ mask;
				we = 1'b1;
			end
			OP_TST_BIT: begin
				rdata = {31'd0, |(cur_byte & mask)};
			end
			OP_TCLR_BIT: begin
				rdata = {31'd0, |(cur_byte & mask)};
				new_byte = cur_byte & ~mask;
				we = 1'b1;
			end
			OP_WR_BYTE: begin
				new_byte = wdata_s1[7:0];
				we = 1'b1;
			end
			OP_RD_BYTE: begin
				rdata = {24'd0, cur_byte};
			end
			default: begin
				new_byte = cur_byte;
			end
		endcase
		case (lane)
			2'd0:    new_row[31:24] = new_byte;
			2'd1:    new_row[23:16] = new_byte;
			2'd2:    new_row[15:8] = new_byte;
			default: new_row[7:0] = new_byte;
		endcase
		case (op_s1)
			OP_WR_WORD: begin
				if (idx_s1[0]) begin
					new_row[15:0] = wdata_s1[15:0];
				end else begin
					new_row[31:16] = wdata_s1[15:0];
				end
				we = 1'b1;
			end
			OP_RD_WORD: begin
				rdata = idx_s1[0] ? {16'd0, row_data[15:0]} : {16'd0, row_data[31:16]};
			end
			OP_WR_DWORD: begin
				new_row = wdata_s1;
				we = 1'b1;
			end
			OP_RD_DWORD: begin
				rdata = row_data;
			end
			default: begin
				new_row = new_row;
			end
		endcase
		if (!valid_s1 || oor_s1) begin
			we = 1'b0;
			rdata = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			wb_vld_q <= 1'b0;
			done <= 1'b0;
		end else begin
			if (we) begin
				row_vld_q[row_s1] <= 1'b1;
			end
			wb_vld_q <= we;
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			wb_row_q <= row_s1;
			wb_data_q <= new_row;
		end
		if (valid_s1) begin
			rsp.read_data <= rdata;
			rsp.out_of_range <= oor_s1;
		end
	end

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("result beat missing");

	a_oor_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.out_of_range |-> rsp.read_data == 32'd0)
		else $error("out of range access returned data");

	a_test_is_bit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (op_s1 == OP_TST_BIT || op_s1 == OP_TCLR_BIT) |=>
		rsp.read_data[31:1] == 31'd0)
		else $error("bit test result wider than one bit");

	a_no_oor_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && oor_s1 |-> !we)
		else $error("write issued for out of range index");

	a_fwd_track: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> wb_vld_q && wb_row_q == $past(row_s1))
		else $error("write-back forward register lost");

endmodule

// ===== test/bafs_checker.sv =====
// Checker for the flag store: watches command and result beats, predicts and compares.
module bafs_checker
	import bafs_pkg::*;
#(
	parameter int FLAG_BYTES = FLAG_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  cmd_t cmd,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending_count,
	output int   checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] flag_mem [FLAG_BYTES];
	rsp_t       expected_rsp_q[$];

	function automatic rsp_t apply_access(cmd_t c);
		rsp_t        r;
		int unsigned byte_no;
		logic [7:0]  bit_mask;
		logic [7:0]  old_byte;
		r = '0;
		case (c.operation)
		OP_SET_BIT, OP_CLR_BIT, OP_TGL_BIT, OP_TST_BIT, OP_TCLR_BIT: begin
			byte_no  = c.index >> 3;
			bit_mask = 8'h80 >> c.index[2:0];
			if (byte_no >= FLAG_BYTES) begin
				r.out_of_range = 1'b1;
			end else begin
				old_byte = flag_mem[byte_no];
				case (c.operation)
				OP_SET_BIT: flag_mem[byte_no] = old_byte | bit_mask;
				OP_CLR_BIT: flag_mem[byte_no] = old_byte & ~bit_mask;
				OP_TGL_BIT: flag_mem[byte_no] = old_byte ^ bit_mask;
				OP_TST_BIT: r.read_data = 32'((old_byte & bit_mask) != 8'h00);
				default: begin
					r.read_data = 32'((old_byte & bit_mask) != 8'h00);
					flag_mem[byte_no] = old_byte & ~bit_mask;
				end
				endcase
			end
		end
		OP_WR_BYTE, OP_RD_BYTE: begin
			if (c.index >= FLAG_BYTES) begin
				r.out_of_range = 1'b1;
			end else if (c.operation == OP_WR_BYTE) begin
				flag_mem[c.index] = c.write_data[7:0];
			end else begin
				r.read_data = {24'h0, flag_mem[c.index]};
			end
		end
		OP_WR_WORD, OP_RD_WORD: begin
			byte_no = c.index * 2;
			if (c.index >= FLAG_BYTES / 2) begin
				r.out_of_range = 1'b1;
			end else if (c.operation == OP_WR_WORD) begin
				flag_mem[byte_no]     = c.write_data[15:8];
				flag_mem[byte_no + 1] = c.write_data[7:0];
			end else begin
				r.read_data = {16'h0, flag_mem[byte_no], flag_mem[byte_no + 1]};
			end
		end
		OP_WR_DWORD, OP_RD_DWORD: begin
			byte_no = c.index * 4;
			if (c.index >= FLAG_BYTES / 4) begin
				r.out_of_range = 1'b1;
			end else if (c.operation == OP_WR_DWORD) begin
				flag_mem[byte_no]     = c.write_data[31:24];
				flag_mem[byte_no + 1] = c.write_data[23:16];
				flag_mem[byte_no + 2] = c.write_data[15:8];
				flag_mem[byte_no + 3] = c.write_data[7:0];
			end else begin
				r.read_data = {flag_mem[byte_no], flag_mem[byte_no + 1],
					flag_mem[byte_no + 2], flag_mem[byte_no + 3]};
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int   errs;
		errs = 0;
		if (!arst_n) begin
			for (int i = 0; i < FLAG_BYTES; i++)
				flag_mem[i] = '0;
			expected_rsp_q.delete();
			fail_count    <= 0;
			pending_count <= 0;
			checked_count <= 0;
		end else begin
			if (start && !busy)
				expected_rsp_q.push_back(apply_access(cmd));
			if (done === 1'b1) begin
				if (expected_rsp_q.size() == 0) begin
					$error("result beat with nothing expected: read_data %h out_of_range %b",
						rsp.read_data, rsp.out_of_range);
					errs++;
				end else begin
					want = expected_rsp_q.pop_front();
					checked_count <= checked_count + 1;
					if (rsp.read_data !== want.read_data) begin
						$error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
						errs++;
					end
					if (rsp.out_of_range !== want.out_of_range) begin
						$error("out_of_range: expected %b, got %b",
							want.out_of_range, rsp.out_of_range);
						errs++;
					end
				end
			end
			fail_count    <= fail_count + errs;
			pending_count <= expected_rsp_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the flag store: clock, reset, command stimulus and verdict.
module tb_top;
	import bafs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1700;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;
	int   fail_count;
	int   pending_count;
	int   checked_count;
	int   sent_count;
	bit   op_seen [16];

	bit_addressable_flag_store_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	bafs_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.done          (done),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic issue_cmd(input logic [3:0] op, input logic [7:0] idx,
		input logic [31:0] wdata);
		start <= 1'b1;
		cmd   <= '{operation: op, index: idx, write_data: wdata};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent_count++;
		op_seen[op] = 1'b1;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_index(logic [3:0] op);
		int unsigned span;
		if (op <= OP_TCLR_BIT)
			span = FLAG_BYTES_DEF * 8;
		else if (op <= OP_RD_BYTE)
			span = FLAG_BYTES_DEF;
		else if (op <= OP_RD_WORD)
			span = FLAG_BYTES_DEF / 2;
		else
			span = FLAG_BYTES_DEF / 4;
		if (span > 256)
			span = 256;
		if ($urandom_range(0, 99) < 12)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, span - 1));
	endfunction

	initial begin
		int          burst_len;
		int          gap_len;
		int          remaining;
		int          n_ops;
		logic [3:0]  op;
		logic [31:0] wdata;
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		sent_count = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue_cmd(OP_RD_DWORD, 8'd0, 32'h0);
		issue_cmd(OP_SET_BIT, 8'd0, 32'h0);
		issue_cmd(OP_SET_BIT, 8'd255, 32'hFFFF_FFFF);
		issue_cmd(OP_TST_BIT, 8'd0, 32'h0);
		issue_cmd(OP_TST_BIT, 8'd1, 32'h0);
		issue_cmd(OP_TGL_BIT, 8'd7, 32'h0);
		issue_cmd(OP_TCLR_BIT, 8'd255, 32'h0);
		issue_cmd(OP_TST_BIT, 8'd255, 32'h0);
		issue_cmd(OP_CLR_BIT, 8'd0, 32'h0);
		issue_cmd(OP_WR_BYTE, 8'd31, 32'hFFFF_FFFF);
		issue_cmd(OP_RD_BYTE, 8'd31, 32'h0);
		issue_cmd(OP_WR_BYTE, 8'd32, 32'h0000_00AA);
		issue_cmd(OP_RD_BYTE, 8'd255, 32'h0);
		issue_cmd(OP_WR_WORD, 8'd15, 32'hFFFF_ABCD);
		issue_cmd(OP_RD_WORD, 8'd15, 32'h0);
		issue_cmd(OP_WR_WORD, 8'd16, 32'h1111_2222);
		issue_cmd(OP_RD_WORD, 8'd16, 32'h0);
		issue_cmd(OP_WR_DWORD, 8'd0, 32'h1234_5678);
		issue_cmd(OP_WR_DWORD, 8'd7, 32'hFFFF_FFFF);
		issue_cmd(OP_RD_DWORD, 8'd0, 32'h0);
		issue_cmd(OP_RD_WORD, 8'd0, 32'h0);
		issue_cmd(OP_RD_BYTE, 8'd1, 32'h0);
		issue_cmd(OP_WR_DWORD, 8'd8, 32'hDEAD_BEEF);
		issue_cmd(OP_RD_DWORD, 8'd255, 32'h0);
		issue_cmd(4'd11, 8'd0, 32'h0);
		issue_cmd(4'd15, 8'd255, 32'hFFFF_FFFF);

		remaining = N_RANDOM;
		while (remaining > 0) begin
			burst_len = $urandom_range(1, 40);
			if (burst_len > remaining)
				burst_len = remaining;
			for (int i = 0; i < burst_len; i++) begin
				if ($urandom_range(0, 99) < 6)
					op = 4'($urandom_range(11, 15));
				else
					op = 4'($urandom_range(OP_SET_BIT, OP_RD_DWORD));
				case ($urandom_range(0, 9))
				0:       wdata = 32'h0;
				1:       wdata = 32'hFFFF_FFFF;
				default: wdata = $urandom;
				endcase
				issue_cmd(op, pick_index(op), wdata);
			end
			remaining -= burst_len;
			gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap_len > 0) begin
				start <= 1'b0;
				repeat (gap_len) @(negedge clk);
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		n_ops = 0;
		foreach (op_seen[i])
			if (op_seen[i])
				n_ops++;
		$display("Run: %0d command beats sent in random bursts, %0d result beats checked.",
			sent_count, checked_count);
		$display("Covered %0d of 16 operation codes, in-range and out-of-range indexes.",
			n_ops);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bafs_pkg.sv
rtl/bafs_ram.sv
rtl/bit_addressable_flag_store_unit.sv
test/bafs_checker.sv
test/tb_top.sv
